// ----- design/bba_pkg.sv -----
// Shared types and constants for the bitmap block allocator.
// No dependencies; imported by the allocator unit, the controller and the datapath.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int MAX_BLOCKS_DEF = 8192;
    localparam int WORD_BITS_DEF  = 64;

    localparam int BLK_W       = 13;  // block_number / granted_block
    localparam int CFG_W       = 14;  // widest configuration register
    localparam int CFG_INDEX_W = 1;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_BLOCKS     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_DATA_BLOCK = 1'b1;

    localparam logic [CFG_W-1:0] TOTAL_BLOCKS_RST     = 14'd8192;
    localparam logic [CFG_W-1:0] FIRST_DATA_BLOCK_RST = 14'd1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        RESP_OK           = 2'd0,
        RESP_FULL         = 2'd1,
        RESP_ALREADY_FREE = 2'd2,
        RESP_RANGE        = 2'd3
    } resp_t;

    typedef enum logic [2:0] {
        CTRL_CLEAR,
        CTRL_IDLE,
        CTRL_START,
        CTRL_CHECK,
        CTRL_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic  clr_en;     // write a zero word during the clearing pass
        logic  load;       // capture an accepted input word
        logic  rd_en;      // read the bitmap
        logic  rd_next;    // read at the following word address
        logic  advance;    // step to the next bitmap word
        logic  wr_en;      // write back the updated bitmap word
        logic  res_load;   // capture the pending result
        logic  res_grant;  // pending result carries the found block
        resp_t res_code;
        logic  out_load;   // move the pending result to the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic quick_fail;  // start point at or above the limit
        logic is_free;
        logic found;       // free block seen in the current word
        logic last_word;   // current word holds the last block below the limit
        logic in_word;     // freed block lies in the current word
        logic bit_set;
        logic out_busy;
    } sts_t;

endpackage

// ----- design/bitmap_block_allocator_unit.sv -----
// First-fit block allocator over a used/free bitmap held in RAM, one bit per
// block, WORD_BITS blocks per RAM word. After reset a clearing pass writes one
// word per cycle over ceil(MAX_BLOCKS / WORD_BITS) words (128 by default), and no
// word is taken until it ends; configuration writes are taken at any time.
// An item is taken in CTRL_IDLE and goes through CTRL_START, CTRL_CHECK (once
// per bitmap word read, one word per cycle through the single read port) and
// CTRL_FINISH, which moves its result to the output register once that is free.
// An allocate reads from the word holding the first data block (from word 0
// when WORD_BITS is not a power of two) up to the word holding the granted
// block (or the last allocatable block); a free reads one word when WORD_BITS
// is a power of two, otherwise every word up to the one holding the block. A
// range or no-space answer is found in CTRL_START, before any read, and the
// item goes straight to CTRL_FINISH. One item is in progress at a time; the
// output register lets the next word in while a result waits on m_tready.
// Depends on bba_pkg, bba_ctrl, bba_datapath and bba_ram.
`timescale 1ns / 1ps

module bitmap_block_allocator_unit #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bba_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bba_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bba_pkg::IN_DATA_W-1:0]   s_tdata,   // [12:0] block_number
    input  logic                            s_tuser,   // [0] command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bba_pkg::OUT_DATA_W-1:0]  m_tdata    // [12:0] granted_block, [14:13] status
);

    import bba_pkg::*;

    cmd_t             cmd;
    sts_t             sts;
    logic [BLK_W-1:0] out_granted;
    resp_t            out_status;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .WORD_BITS  (WORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_cmd      (s_tuser),
        .in_block    (s_tdata[BLK_W-1:0]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_granted (out_granted),
        .out_status  (out_status),
        .cmd         (cmd),
        .sts         (sts)
    );

    assign m_tdata = {{(OUT_DATA_W - BLK_W - 2){1'b0}}, out_status, out_granted};

    // one word in flight: no second accept straight after the first
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // only a successful allocate carries a block number
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_granted != '0) |-> (out_status == RESP_OK))
        else $error("non-zero block with a failing status");

    // a fresh result never lands while an unaccepted one is still shown
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && m_tvalid))
        else $error("pending result overwritten");

endmodule

// ----- design/bba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/bba_datapath.sv -----
// Datapath: configuration registers, bitmap RAM, word scan, result registers.
// Depends on bba_pkg and bba_ram.
`timescale 1ns / 1ps

module bba_datapath #(
    parameter int MAX_BLOCKS = 8192,
    parameter int WORD_BITS  = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bba_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bba_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_cmd,
    input  logic [bba_pkg::BLK_W-1:0]     in_block,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [bba_pkg::BLK_W-1:0]     out_granted,
    output bba_pkg::resp_t                out_status,
    input  bba_pkg::cmd_t                 cmd,
    output bba_pkg::sts_t                 sts
);

    import bba_pkg::*;

    localparam int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int NW_SPAN    = $clog2(WORD_COUNT * WORD_BITS + WORD_BITS + 1);
    localparam int NW         = (NW_SPAN > CFG_W + 1) ? NW_SPAN : CFG_W + 1;
    localparam int OW         = $clog2(WORD_BITS + 1);
    localparam int LW         = $clog2(WORD_BITS);
    localparam bit WB_POW2    = (WORD_BITS & (WORD_BITS - 1)) == 0;

    logic [CFG_W-1:0] total_reg;
    logic [CFG_W-1:0] first_reg;

    logic [NW-1:0] lim_reg;
    logic [NW-1:0] target_reg;
    logic [NW-1:0] base_reg;
    logic [AW-1:0] w_reg;
    logic          free_reg;
    logic [AW-1:0] clr_reg;

    logic [BLK_W-1:0] res_granted_reg;
    resp_t            res_status_reg;
    logic             out_valid_reg;
    logic [BLK_W-1:0] out_granted_reg;
    resp_t            out_status_reg;

    logic [NW-1:0] total_ext;
    logic [NW-1:0] lim_new;
    logic [NW-1:0] first_ext;
    logic [NW-1:0] target_new;
    logic [NW-1:0] base_new;
    logic [AW-1:0] w_new;

    logic [NW-1:0]        diff_lo;
    logic [NW-1:0]        diff_hi;
    logic [NW-1:0]        base_step;
    logic [OW-1:0]        lo_off;
    logic [OW-1:0]        hi_off;
    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] free_vec;
    logic [LW-1:0]        found_idx;
    logic [LW-1:0]        bit_idx;
    logic [WORD_BITS-1:0] new_word;
    logic [NW-1:0]        granted_full;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_BLOCKS_RST;
            first_reg <= FIRST_DATA_BLOCK_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_TOTAL_BLOCKS)
            begin
                total_reg <= cfg_data;
            end
            if (cfg_index == CFG_FIRST_DATA_BLOCK)
            begin
                first_reg <= cfg_data;
            end
        end
    end

    // ---- set-up of a new word ----
    always_comb
    begin
        total_ext  = NW'(total_reg);
        lim_new    = (total_ext > NW'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS) : total_ext;
        first_ext  = (first_reg == '0) ? NW'(1) : NW'(first_reg);
        target_new = (in_cmd == CMD_ALLOC) ? first_ext : NW'(in_block);
        // power-of-two words let the scan start at the right word directly
        if (WB_POW2)
        begin
            w_new    = AW'(target_new >> LW);
            base_new = target_new & ~NW'(WORD_BITS - 1);
        end
        else
        begin
            w_new    = '0;
            base_new = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lim_reg    <= lim_new;
            target_reg <= target_new;
            free_reg   <= (in_cmd == CMD_FREE);
            w_reg      <= w_new;
            base_reg   <= base_new;
        end
        else if (cmd.advance)
        begin
            w_reg    <= w_reg + AW'(1);
            base_reg <= base_step;
        end
    end

    // ---- word evaluation ----
    always_comb
    begin
        diff_lo   = target_reg - base_reg;
        diff_hi   = lim_reg - base_reg;
        base_step = base_reg + NW'(WORD_BITS);

        if (target_reg <= base_reg)
            lo_off = '0;
        else if (diff_lo >= NW'(WORD_BITS))
            lo_off = OW'(WORD_BITS);
        else
            lo_off = diff_lo[OW-1:0];

        if (lim_reg <= base_reg)
            hi_off = '0;
        else if (diff_hi >= NW'(WORD_BITS))
            hi_off = OW'(WORD_BITS);
        else
            hi_off = diff_hi[OW-1:0];

        for (int i = 0; i < WORD_BITS; i++)
        begin
            free_vec[i] = !rdata[i] && (OW'(i) >= lo_off) && (OW'(i) < hi_off);
        end

        // lowest free bit wins
        found_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_vec[i])
                found_idx = LW'(i);
        end

        bit_idx      = diff_lo[LW-1:0];
        granted_full = base_reg + NW'(found_idx);

        if (free_reg)
            new_word = rdata & ~(WORD_BITS'(1) << bit_idx);
        else
            new_word = rdata | (WORD_BITS'(1) << found_idx);
    end

    // ---- bitmap store and clearing pass ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_en)
            clr_reg <= clr_reg + AW'(1);
    end

    assign ram_we    = cmd.clr_en || cmd.wr_en;
    assign ram_waddr = cmd.clr_en ? clr_reg : w_reg;
    assign ram_wdata = cmd.clr_en ? '0 : new_word;
    assign ram_raddr = cmd.rd_next ? (w_reg + AW'(1)) : w_reg;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT),
        .AW    (AW)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    // ---- result and output registers ----
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_granted_reg <= cmd.res_grant ? granted_full[BLK_W-1:0] : '0;
            res_status_reg  <= cmd.res_code;
        end
        if (cmd.out_load)
        begin
            out_granted_reg <= res_granted_reg;
            out_status_reg  <= res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid    = out_valid_reg;
    assign out_granted = out_granted_reg;
    assign out_status  = out_status_reg;

    always_comb
    begin
        sts.clr_last   = (clr_reg == AW'(WORD_COUNT - 1));
        sts.quick_fail = (target_reg >= lim_reg);
        sts.is_free    = free_reg;
        sts.found      = |free_vec;
        sts.last_word  = (base_step >= lim_reg);
        sts.in_word    = (target_reg >= base_reg) && (diff_lo < NW'(WORD_BITS));
        sts.bit_set    = rdata[bit_idx];
        sts.out_busy   = out_valid_reg && !m_tready;
    end

endmodule

// ----- design/bba_ctrl.sv -----
// Controller state machine: clearing pass, word scan sequencing, result hand-off.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  bba_pkg::sts_t sts,
    output bba_pkg::cmd_t cmd
);

    import bba_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CTRL_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_code = RESP_OK;
        s_tready   = 1'b0;

        unique case (state_reg)
            CTRL_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                    state_next = CTRL_IDLE;
            end

            CTRL_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = CTRL_START;
                end
            end

            CTRL_START:
            begin
                if (sts.quick_fail)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = sts.is_free ? RESP_RANGE : RESP_FULL;
                    state_next   = CTRL_FINISH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = CTRL_CHECK;
                end
            end

            CTRL_CHECK:
            begin
                if (!sts.is_free)
                begin
                    priority if (sts.found)
                    begin
                        cmd.wr_en     = 1'b1;
                        cmd.res_load  = 1'b1;
                        cmd.res_grant = 1'b1;
                        cmd.res_code  = RESP_OK;
                        state_next    = CTRL_FINISH;
                    end
                    else if (sts.last_word)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = RESP_FULL;
                        state_next   = CTRL_FINISH;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_next = 1'b1;
                    end
                end
                else
                begin
                    priority if (sts.in_word && sts.bit_set)
                    begin
                        cmd.wr_en    = 1'b1;
                        cmd.res_load = 1'b1;
                        cmd.res_code = RESP_OK;
                        state_next   = CTRL_FINISH;
                    end
                    else if (sts.in_word)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = RESP_ALREADY_FREE;
                        state_next   = CTRL_FINISH;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_next = 1'b1;
                    end
                end
            end

            CTRL_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = CTRL_IDLE;
                end
            end

            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

endmodule
